/* hw/rtl/blo_pkg.sv */
// Shared types, constants and control codes of the bounded ordered list.
`timescale 1ns / 1ps
`default_nettype none
package blo_pkg;

  localparam int DEPTH   = 16;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 5;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_STATUS = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef struct packed {
    mode_t                     mode;
    logic signed [DATA_W-1:0]  value;
    logic signed [DATA_W-1:0]  key;
  } req_t;

  typedef struct packed {
    status_t                   status;
    logic [COUNT_W-1:0]        count;
    logic                      is_full;
    logic                      is_empty;
    logic signed [DATA_W-1:0]  removed_value;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SEARCH,
    S_SHIFT,
    S_RM_WAIT,
    S_RESP
  } ctrl_state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_APPEND,
    DP_RM_READ,
    DP_RM_DONE,
    DP_SEARCH,
    DP_SHIFT_INIT,
    DP_SHIFT,
    DP_INSERT
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    logic    set_status;
    status_t status;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  full;
    logic  empty;
    logic  few;
    logic  match;
    logic  hit_edge;
    logic  search_end;
    logic  shift_end;
    logic  out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/blo_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module blo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hw/rtl/blo_ctrl.sv */
// Controller state machine that sequences each request through the datapath.
`timescale 1ns / 1ps
`default_nettype none
module blo_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire blo_pkg::dp_stat_t  stat,
  output blo_pkg::dp_cmd_t        cmd
);
  import blo_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd.op         = DP_NOP;
    cmd.set_status = 1'b0;
    cmd.status     = ST_DONE;
    cmd.load_out   = 1'b0;
    req_ready      = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.op     = DP_LOAD;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_RESP;
        case (stat.mode)
          MODE_APPEND: begin
            if (stat.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
            end else begin
              cmd.op = DP_APPEND;
            end
          end
          MODE_INSERT: begin
            if (stat.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
            end else if (stat.few) begin
              // Fewer than three entries leave no middle position.
              cmd.set_status = 1'b1;
              cmd.status     = ST_BADPOS;
            end else begin
              cmd.op     = DP_SEARCH;
              state_next = S_SEARCH;
            end
          end
          MODE_REMOVE: begin
            if (stat.empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_EMPTY;
            end else begin
              cmd.op     = DP_RM_READ;
              state_next = S_RM_WAIT;
            end
          end
          default: begin
            state_next = S_RESP;
          end
        endcase
      end
      S_SEARCH: begin
        if (stat.match) begin
          if (stat.hit_edge) begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_BADPOS;
            state_next     = S_RESP;
          end else begin
            cmd.op     = DP_SHIFT_INIT;
            state_next = S_SHIFT;
          end
        end else if (stat.search_end) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_BADPOS;
          state_next     = S_RESP;
        end else begin
          cmd.op = DP_SEARCH;
        end
      end
      S_SHIFT: begin
        if (stat.shift_end) begin
          cmd.op     = DP_INSERT;
          state_next = S_RESP;
        end else begin
          cmd.op = DP_SHIFT;
        end
      end
      S_RM_WAIT: begin
        cmd.op     = DP_RM_DONE;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/blo_dp.sv */
// Datapath: request latch, list pointers, entry memory, scan and shift logic, result register.
`timescale 1ns / 1ps
`default_nettype none
module blo_dp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire blo_pkg::req_t      req,
  input  wire blo_pkg::dp_cmd_t   cmd,
  output blo_pkg::dp_stat_t       stat,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output blo_pkg::rsp_t           rsp
);
  import blo_pkg::*;

  // Logical list position to physical memory slot, wrapping at the list depth.
  function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] h,
                                             input logic [CNT_W-1:0]  l);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(h) + (CNT_W+1)'(l);
    if (s >= (CNT_W+1)'(DEPTH)) begin
      s = s - (CNT_W+1)'(DEPTH);
    end
    return s[ADDR_W-1:0];
  endfunction

  req_t                     cur;
  status_t                  status;
  logic signed [DATA_W-1:0] removed;
  logic [ADDR_W-1:0]        head;
  logic [CNT_W-1:0]         fill;
  logic [CNT_W-1:0]         pos;
  logic [CNT_W-1:0]         rd_pos;
  logic [CNT_W-1:0]         hit;
  logic                     pending;

  logic                     ram_we;
  logic [CNT_W-1:0]         wr_log;
  logic [CNT_W-1:0]         rd_log;
  logic [DATA_W-1:0]        ram_wdata;
  logic [DATA_W-1:0]        ram_rdata;
  logic                     search_issue;
  logic                     shift_issue;
  logic [CNT_W+COUNT_W-1:0] count_ext;

  assign search_issue = (pos < fill);
  assign shift_issue  = (pos >= hit);
  assign count_ext    = {COUNT_W'(0), fill};

  always_comb begin
    ram_we    = 1'b0;
    wr_log    = fill;
    ram_wdata = cur.value;
    rd_log    = pos;
    case (cmd.op)
      DP_APPEND: begin
        ram_we = 1'b1;
      end
      DP_SHIFT: begin
        ram_we    = pending;
        wr_log    = rd_pos + CNT_W'(1);
        ram_wdata = ram_rdata;
      end
      DP_INSERT: begin
        ram_we = 1'b1;
        wr_log = hit;
      end
      DP_RM_READ: begin
        rd_log = '0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  blo_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (phys(head, wr_log)),
    .wdata (ram_wdata),
    .raddr (phys(head, rd_log)),
    .rdata (ram_rdata)
  );

  always_comb begin
    stat.mode       = cur.mode;
    stat.full       = (fill == CNT_W'(DEPTH));
    stat.empty      = (fill == '0);
    stat.few        = (fill < CNT_W'(3));
    stat.match      = pending && ($signed(ram_rdata) == cur.key);
    stat.hit_edge   = (rd_pos == '0) || (rd_pos == fill - CNT_W'(1));
    stat.search_end = !pending && !search_issue;
    stat.shift_end  = !pending && !shift_issue;
    stat.out_busy   = rsp_valid && !rsp_ready;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      fill      <= '0;
      pending   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      pending <= 1'b0;
      case (cmd.op)
        DP_APPEND: begin
          fill <= fill + CNT_W'(1);
        end
        DP_INSERT: begin
          fill <= fill + CNT_W'(1);
        end
        DP_RM_DONE: begin
          fill <= fill - CNT_W'(1);
          head <= (head == ADDR_W'(DEPTH - 1)) ? '0 : head + ADDR_W'(1);
        end
        DP_SEARCH: begin
          pending <= search_issue;
        end
        DP_SHIFT: begin
          pending <= shift_issue;
        end
        default: begin
          pending <= 1'b0;
        end
      endcase
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        cur     <= req;
        status  <= ST_DONE;
        removed <= '0;
        pos     <= '0;
      end
      DP_RM_DONE: begin
        removed <= $signed(ram_rdata);
      end
      DP_SEARCH: begin
        rd_pos <= pos;
        if (search_issue) begin
          pos <= pos + CNT_W'(1);
        end
      end
      DP_SHIFT_INIT: begin
        hit <= rd_pos;
        pos <= fill - CNT_W'(1);
      end
      DP_SHIFT: begin
        rd_pos <= pos;
        if (shift_issue) begin
          pos <= pos - CNT_W'(1);
        end
      end
      default: begin
        pos <= pos;
      end
    endcase
    if (cmd.set_status) begin
      status <= cmd.status;
    end
    if (cmd.load_out) begin
      rsp.status        <= status;
      rsp.count         <= count_ext[COUNT_W-1:0];
      rsp.is_full       <= (fill == CNT_W'(DEPTH));
      rsp.is_empty      <= (fill == '0);
      rsp.removed_value <= removed;
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(DEPTH))
    else $error("list fill exceeds depth");

  a_fill_hold: assert property (@(posedge clk) disable iff (rst)
    (cmd.op != DP_APPEND && cmd.op != DP_INSERT && cmd.op != DP_RM_DONE) |=> $stable(fill))
    else $error("fill changed without an append, insert or remove");

  a_shift_dest: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_SHIFT && pending) |-> (rd_pos < fill && rd_pos >= hit))
    else $error("shift write outside the tail region");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(rsp_valid && !rsp_ready))
    else $error("result loaded over a beat not yet taken");
`endif

endmodule
`default_nettype wire

/* hw/rtl/bounded_ordered_list.sv */
// Top level of the bounded ordered list: controller and datapath.
`timescale 1ns / 1ps
`default_nettype none
// Ordered list of up to DEPTH (16) signed 32-bit words held in a circular
// buffer in a single simple dual-port RAM. Each request beat (append at tail,
// insert before the first entry equal to key, remove head, or status only)
// produces exactly one response beat with a status code, the new count, full
// and empty flags and the removed head value. The block works on one request
// at a time. An append, a status-only request, or an insert refused before
// any search (full list, or fewer than three entries) goes from the decide
// state straight to the response state. A remove passes a wait state too,
// because the head read goes through the registered RAM read port. A middle
// insert first scans the list from the head, one entry per cycle. When the
// first match is the head or the tail, or no entry matches, the insert is
// refused. Otherwise every entry from the tail back to the match moves up
// by one slot, again one entry per cycle. The next request beat is taken in
// the cycle after the response is loaded into the output register, even if
// that response beat is still waiting on rsp_ready. Entry storage is not
// cleared at reset; only entries already written are ever read, so the
// block is ready as soon as reset is released.
module bounded_ordered_list (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire blo_pkg::req_t  req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output blo_pkg::rsp_t       rsp
);
  import blo_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller decides each step; the datapath holds the list and the
  // result register and reports flags back.
  blo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  blo_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for the bounded ordered list, with its scoreboard class.
`timescale 1ns / 1ps

// Scoreboard: keeps a shadow copy of the list and a queue of awaited responses.
class list_scoreboard;
  logic signed [blo_pkg::DATA_W-1:0] shadow[$];
  blo_pkg::rsp_t awaited[$];
  int errors;
  int checked;

  function int fill();
    return shadow.size();
  endfunction

  function logic signed [blo_pkg::DATA_W-1:0] entry_at(int idx);
    return shadow[idx];
  endfunction

  function int outstanding();
    return awaited.size();
  endfunction

  // Applies one accepted request to the shadow list and queues its response.
  function void note_request(blo_pkg::req_t r);
    blo_pkg::rsp_t e;
    int hit;
    int n;
    e = '0;
    e.status = blo_pkg::ST_DONE;
    case (r.mode)
      blo_pkg::MODE_APPEND: begin
        if (shadow.size() >= blo_pkg::DEPTH) e.status = blo_pkg::ST_FULL;
        else shadow.push_back(r.value);
      end
      blo_pkg::MODE_INSERT: begin
        if (shadow.size() >= blo_pkg::DEPTH) begin
          e.status = blo_pkg::ST_FULL;
        end else begin
          // Only the first match counts; head, tail or no match is refused.
          hit = -1;
          foreach (shadow[i]) if (hit < 0 && shadow[i] == r.key) hit = i;
          if (hit <= 0 || hit == shadow.size() - 1) e.status = blo_pkg::ST_BADPOS;
          else shadow.insert(hit, r.value);
        end
      end
      blo_pkg::MODE_REMOVE: begin
        if (shadow.size() == 0) e.status = blo_pkg::ST_EMPTY;
        else e.removed_value = shadow.pop_front();
      end
      default: begin
      end
    endcase
    n = shadow.size();
    e.count = n[blo_pkg::COUNT_W-1:0];
    e.is_full = (n == blo_pkg::DEPTH);
    e.is_empty = (n == 0);
    awaited.push_back(e);
  endfunction

  function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
    if (want !== seen) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, seen);
      errors++;
    end
  endfunction

  // Checks one response beat against the oldest awaited response.
  function void check_response(blo_pkg::rsp_t got);
    blo_pkg::rsp_t e;
    if (awaited.size() == 0) begin
      $display("%0t: response beat with nothing awaited, expected none, got %h", $time, got);
      errors++;
      return;
    end
    e = awaited.pop_front();
    checked++;
    compare_field("status", e.status, got.status);
    compare_field("count", e.count, got.count);
    compare_field("is_full", e.is_full, got.is_full);
    compare_field("is_empty", e.is_empty, got.is_empty);
    compare_field("removed_value", e.removed_value, got.removed_value);
  endfunction
endclass

module tb_top;
  import blo_pkg::*;

  localparam int RANDOM_ITEMS = 500;
  // The slowest request is a middle insert into a list one short of full;
  // even with sender gaps and receiver stalls, the limit is far above it.
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 2 * DEPTH + 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  list_scoreboard board;
  int cycle_count = 0;
  int mode_tally[4];
  // When set, neither side inserts idle cycles.
  bit steady = 1'b0;

  bounded_ordered_list dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #1 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d responses outstanding.",
               cycle_count, board.outstanding());
      $display("Mismatches found");
      $finish;
    end
  end

  // The response side stalls in about one cycle of ten, except during the
  // steady stretch. It changes only at the falling edge.
  always @(negedge clk) begin
    rsp_ready <= rst ? 1'b0 : (steady || $urandom_range(99) >= 10);
  end

  // Every response beat is checked at the rising edge that accepts it.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) board.check_response(rsp);
  end

  // Drives one request beat. The sender may idle first; once valid is up it
  // stays up with the same payload until the beat is accepted.
  task automatic send_request(input req_t item);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 10) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (!req_ready);
    board.note_request(item);
    mode_tally[item.mode]++;
  endtask

  task automatic apply(input mode_t m, input logic signed [DATA_W-1:0] v,
                       input logic signed [DATA_W-1:0] k);
    req_t item;
    item.mode = m;
    item.value = v;
    item.key = k;
    send_request(item);
  endtask

  // Values from a tiny pool make duplicate entries, so first-match rules
  // get exercised; the rest are full-width random words.
  function automatic logic signed [DATA_W-1:0] pick_value();
    if ($urandom_range(99) < 50) return int'($urandom_range(6)) - 3;
    return $urandom;
  endfunction

  // Insert keys mostly name a middle entry of the current list, so the
  // search and shift paths are reached; some hit the ends or miss entirely.
  function automatic logic signed [DATA_W-1:0] pick_key();
    int n;
    int roll;
    n = board.fill();
    roll = $urandom_range(99);
    if (n >= 3 && roll < 70) return board.entry_at($urandom_range(n - 2, 1));
    if (n > 0 && roll < 80) return board.entry_at(roll[0] ? 0 : n - 1);
    if (roll < 90) return int'($urandom_range(6)) - 3;
    return $urandom;
  endfunction

  // Short directed part: empty and full refusals, extreme words, inserts
  // that match the head, the tail, nothing, or a middle entry, and an
  // insert whose key matches the head first and a later entry too.
  task automatic run_directed();
    apply(MODE_STATUS, 0, 0);
    apply(MODE_REMOVE, 0, 0);
    apply(MODE_INSERT, 32'sd9, 32'sd0);
    apply(MODE_APPEND, 32'h7FFF_FFFF, 0);
    apply(MODE_APPEND, 32'h8000_0000, 0);
    apply(MODE_APPEND, 0, 0);
    apply(MODE_APPEND, 32'hFFFF_FFFF, 0);
    apply(MODE_INSERT, 32'sd7, 32'h7FFF_FFFF);
    apply(MODE_INSERT, 32'sd7, 32'hFFFF_FFFF);
    apply(MODE_INSERT, 32'sd7, 32'sd12345);
    apply(MODE_INSERT, 32'h5A5A_5A5A, 32'h8000_0000);
    apply(MODE_INSERT, 32'sd1, 32'sd0);
    apply(MODE_APPEND, 32'h7FFF_FFFF, 0);
    apply(MODE_INSERT, 32'sd2, 32'h7FFF_FFFF);
    apply(MODE_REMOVE, 0, 0);
    for (int i = 0; i < 10; i++) apply(MODE_APPEND, 32'hA5A5_0000 ^ (i << 28), i);
    apply(MODE_APPEND, 32'sd3, 0);
    apply(MODE_INSERT, 32'sd4, 32'sd0);
    apply(MODE_STATUS, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // Random part: phases that lean toward filling alternate with phases that
  // lean toward draining, so the list swings between empty and full.
  task automatic run_random(input int total);
    req_t item;
    int roll;
    int phase_left;
    bit filling;
    filling = 1'b1;
    phase_left = 40;
    for (int k = 0; k < total; k++) begin
      steady = (k >= total / 3 && k < total / 3 + 120);
      if (phase_left == 0) begin
        filling = !filling;
        phase_left = $urandom_range(60, 20);
      end
      phase_left--;
      roll = $urandom_range(99);
      item.value = pick_value();
      item.key = $urandom;
      if (roll >= 93) item.mode = MODE_STATUS;
      else if (roll < (filling ? 45 : 15)) item.mode = MODE_APPEND;
      else if (roll < (filling ? 75 : 30)) item.mode = MODE_INSERT;
      else item.mode = MODE_REMOVE;
      if (item.mode == MODE_INSERT) item.key = pick_key();
      send_request(item);
    end
    steady = 1'b0;
  endtask

  initial begin
    board = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    run_random(RANDOM_ITEMS);
    @(negedge clk);
    req_valid <= 1'b0;

    // Wait for every awaited response, then a little longer so a stray
    // extra beat would still be caught.
    while (board.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d response beats for %0d appends, %0d inserts, %0d removes,",
             board.checked, mode_tally[MODE_APPEND], mode_tally[MODE_INSERT],
             mode_tally[MODE_REMOVE]);
    $display("and %0d status reads, across empty, partly filled and full lists.",
             mode_tally[MODE_STATUS]);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
